FILE: rtl/windowed_rms_level_meter_top_macros.svh
// ---------------------------------------------------------------------------
// windowed rms level meter assertion macros
// concurrent checks clocked on clock and disabled in reset
// ---------------------------------------------------------------------------
`ifndef WINDOWED_RMS_LEVEL_METER_TOP_MACROS_SVH
`define WINDOWED_RMS_LEVEL_METER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define WRMS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wrms check failed in the same cycle");

// consequent checked in the following cycle
`define WRMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wrms check failed one cycle later");

`endif

FILE: rtl/wrms_pkg.sv
// ---------------------------------------------------------------------------
// wrms_pkg
// shared types and constants of the windowed rms level meter
// ---------------------------------------------------------------------------
package wrms_pkg;

   localparam int WL_W       = 14;
   localparam int THR_W      = 24;
   localparam int LEVEL_W    = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [WL_W-1:0]  WL_RESET  = 14'd4800;
   localparam logic [THR_W-1:0] THR_RESET = 24'd839;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_THRESHOLD = 1'b1;

   // width of the sum of squares for a given sample width
   function automatic int sum_width(input int sample_bits);
      return 2 * sample_bits + WL_W - 1;
   endfunction

   typedef struct packed {
      logic accept;
      logic sq_new;
      logic add_new;
      logic sub_old;
      logic div_load;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

endpackage

FILE: rtl/wrms_dp.sv
// ---------------------------------------------------------------------------
// wrms_dp
// sample ring, running sum of squares, serial divider and serial square root
// ---------------------------------------------------------------------------
module wrms_dp #(
   parameter int RING_DEPTH  = 8192,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wrms_pkg::cmd_type                 cmd,
   input  logic [SAMPLE_BITS-1:0]            sample,
   input  logic                              csr_wr_en,
   input  logic [wrms_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [wrms_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [wrms_pkg::LEVEL_W-1:0]      rms_level,
   output logic                              non_silent
);
   import wrms_pkg::*;

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int SUM_W = sum_width(SAMPLE_BITS);
   localparam int RT_W  = (SUM_W + 1) / 2;
   localparam int RAD_W = 2 * RT_W;
   localparam int RR_W  = RT_W + 1;
   localparam logic [31:0] DEPTH_C = 32'(RING_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   // configuration
   logic [WL_W-1:0]  wl_ff;
   logic [THR_W-1:0] thr_ff;
   logic             clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff  <= WL_RESET;
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            REG_WINDOW_LENGTH:     wl_ff  <= csr_wdata[WL_W-1:0];
            REG_SILENCE_THRESHOLD: thr_ff <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign clear = csr_wr_en && (csr_addr == REG_WINDOW_LENGTH);

   // window bookkeeping
   logic [WL_W-1:0]        weff;
   logic                   weff_nz;
   logic                   drop;
   logic [31:0]            old_pos;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wi_ff, wi_in;
   logic [WL_W-1:0]        fill_ff, fill_in;
   logic                   add_ff, add_in;
   logic                   drop_ff, drop_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;

   assign weff    = (32'(wl_ff) > DEPTH_C) ? WL_W'(DEPTH_C) : wl_ff;
   assign weff_nz = (weff != '0);
   assign drop    = weff_nz && (fill_ff >= weff);
   assign old_pos = (32'(wi_ff) >= 32'(weff)) ? (32'(wi_ff) - 32'(weff))
                                              : (32'(wi_ff) + DEPTH_C - 32'(weff));
   assign rd_addr = old_pos[IDX_W-1:0];

   always_comb begin
      wi_in     = wi_ff;
      fill_in   = fill_ff;
      add_in    = add_ff;
      drop_in   = drop_ff;
      sample_in = sample_ff;
      if (clear) begin
         wi_in   = '0;
         fill_in = '0;
      end else if (cmd.accept) begin
         wi_in     = (wi_ff == IDX_LAST) ? '0 : wi_ff + 1'b1;
         fill_in   = drop ? weff : (weff_nz ? fill_ff + 1'b1 : fill_ff);
         add_in    = weff_nz;
         drop_in   = drop;
         sample_in = sample;
      end
   end

   // sample ring, read-first so the leaving sample is seen before overwrite
   logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff            <= ring_mem[rd_addr];
         ring_mem[wi_ff]  <= sample;
      end
   end

   // shared squarer
   logic [SAMPLE_BITS-1:0] mult_src;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SQ_W-1:0]        prod_ff, prod_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   assign mult_src = cmd.sq_new ? sample_ff : rd_ff;
   assign mag      = mult_src[SAMPLE_BITS-1] ? (~mult_src + 1'b1) : mult_src;

   always_comb begin
      prod_in = prod_ff;
      sum_in  = sum_ff;
      if (cmd.sq_new || cmd.add_new) begin
         prod_in = SQ_W'(mag) * SQ_W'(mag);
      end
      if (clear) begin
         sum_in = '0;
      end else if (cmd.add_new && add_ff) begin
         sum_in = sum_ff + SUM_W'(prod_ff);
      end else if (cmd.sub_old && drop_ff) begin
         sum_in = sum_ff - SUM_W'(prod_ff);
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [WL_W-1:0]  rem_ff, rem_in;
   logic [WL_W:0]    div_trial;
   logic [WL_W:0]    div_diff;
   logic             div_ge;

   assign div_trial = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, fill_ff});
   assign div_diff  = div_trial - {1'b0, fill_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.div_load) begin
         quo_in = sum_ff;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[SUM_W-2:0], div_ge};
         rem_in = div_ge ? div_diff[WL_W-1:0] : div_trial[WL_W-1:0];
      end
   end

   // digit-by-digit square root, one root bit a cycle
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RR_W-1:0]  srem_ff, srem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [RR_W+1:0]  sq_shift;
   logic [RR_W+1:0]  sq_trial;
   logic [RR_W+1:0]  sq_diff;
   logic             sq_ge;

   assign sq_shift = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = (sq_shift >= sq_trial);
   assign sq_diff  = sq_shift - sq_trial;

   always_comb begin
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.sqrt_load) begin
         rad_in  = RAD_W'(quo_ff);
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         srem_in = sq_ge ? sq_diff[RR_W-1:0] : sq_shift[RR_W-1:0];
         root_in = {root_ff[RT_W-2:0], sq_ge};
      end
   end

   // output register
   logic [LEVEL_W-1:0] level;
   logic [LEVEL_W-1:0] rms_ff, rms_in;
   logic               ns_ff, ns_in;

   assign level = add_ff ? LEVEL_W'(root_ff) : '0;

   always_comb begin
      rms_in = rms_ff;
      ns_in  = ns_ff;
      if (cmd.out_load) begin
         rms_in = level;
         ns_in  = (level > thr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff   <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         add_ff  <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         wi_ff   <= wi_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         add_ff  <= add_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      rad_ff    <= rad_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      rms_ff    <= rms_in;
      ns_ff     <= ns_in;
   end

   assign rms_level  = rms_ff;
   assign non_silent = ns_ff;

endmodule

FILE: rtl/wrms_ctrl.sv
`include "windowed_rms_level_meter_top_macros.svh"
// ---------------------------------------------------------------------------
// wrms_ctrl
// sequencer for sum update, divide, square root and result handoff
// ---------------------------------------------------------------------------
module wrms_ctrl #(
   parameter int DIV_STEPS  = 61,
   parameter int SQRT_STEPS = 31
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output wrms_pkg::cmd_type cmd
);
   import wrms_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQN  = 4'd1;
   localparam logic [3:0] S_ADD  = 4'd2;
   localparam logic [3:0] S_SUB  = 4'd3;
   localparam logic [3:0] S_DLD  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_SLD  = 4'd6;
   localparam logic [3:0] S_SQRT = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_SQN;
            end
         end
         S_SQN: begin
            cmd.sq_new = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            cmd.add_new = 1'b1;
            state_in    = S_SUB;
         end
         S_SUB: begin
            cmd.sub_old = 1'b1;
            state_in    = S_DLD;
         end
         S_DLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_SLD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SLD: begin
            cmd.sqrt_load = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            // wait for the previous result to leave the output register
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `WRMS_ASSERT_NEXT(a_accept_starts, req_tvalid && req_tready, state_ff == S_SQN)
   `WRMS_ASSERT_SAME(a_load_when_free, cmd.out_load, !rsp_valid_ff || rsp_tready)
   `WRMS_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, rsp_valid_ff && state_ff == S_IDLE)
   `WRMS_ASSERT_SAME(a_div_count_bound, state_ff == S_DIV, cnt_ff <= DIV_LAST)
   `WRMS_ASSERT_NEXT(a_sqrt_ends, state_ff == S_SQRT && cnt_ff == SQRT_LAST, state_ff == S_OUT)

endmodule

FILE: rtl/windowed_rms_level_meter_top.sv
// per sample: square and add the new sample, subtract the leaving one, divide by the fill, take the root
// a new sample is taken only after the previous one has passed the serial divider and root
// the next sample is taken while the previous result still waits in the output register
// reset: synchronous; clears write index, fill count, sum of squares and the handshakes,
// loads window_length 4800 and silence_threshold 839; the ring needs no clearing pass
// ---------------------------------------------------------------------------
// windowed_rms_level_meter_top
// moving-window rms of signed audio samples with a silence flag
// ---------------------------------------------------------------------------
module windowed_rms_level_meter_top #(
   parameter int RING_DEPTH  = 8192,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wrms_pkg::LEVEL_W-1:0]          rsp_tdata,  // rms_level
   output logic                                  rsp_tuser,  // non_silent
   input  logic                                  csr_wr_en,
   input  logic [wrms_pkg::CSR_IDX_W-1:0]        csr_addr,
   input  logic [wrms_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wrms_pkg::*;

   localparam int DIV_STEPS  = sum_width(SAMPLE_BITS);
   localparam int SQRT_STEPS = (DIV_STEPS + 1) / 2;

   cmd_type cmd;

   wrms_ctrl #(
      .DIV_STEPS  (DIV_STEPS),
      .SQRT_STEPS (SQRT_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   wrms_dp #(
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rms_level  (rsp_tdata),
      .non_silent (rsp_tuser)
   );

endmodule
